/* rtl/s2l_pkg.sv */
package s2l_pkg;

    // Default output fraction width
    localparam int FRAC_BITS_DEF = 8;

    // Datapath widths (linear and normalized values are unsigned Q30)
    localparam int LIN_W  = 31;  // linear channel, 0 .. 1.0
    localparam int COEF_W = 24;  // matrix coefficients scaled by 1e7
    localparam int SUM_W  = 56;  // matrix row sums
    localparam int F_W    = 31;  // normalized XYZ and companded values
    localparam int NUM_W  = 46;  // numerator of the linear compand segment
    localparam int SQ_W   = 32;  // c*c >> 30
    localparam int CUBE_W = 33;  // c*c*c >> 60
    localparam int RAW_W  = 44;  // signed Lab before rounding

    // Constant division by reciprocal: q ~ ((n >> PRE) * RCP) >> RCP_W, then corrected
    localparam int RCP_W   = 32;  // reciprocal width
    localparam int DIV_PRE = 23;  // low bits of a row sum dropped before the multiply
    localparam int LIN_PRE = 10;  // low bits of the linear numerator dropped
    localparam int LQ_W    = 28;  // width of the linear numerator slice fed to the multiply

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [LIN_W-1:0] lin_arr_t [256];

    // One lane of the compand pipeline
    typedef struct packed {
        logic             lin;   // linear segment selected
        logic [F_W-1:0]   x;     // normalized input
        logic [F_W-1:0]   c;     // cube root found so far
        logic [F_W-1:0]   cand;  // candidate of the current bit
        logic [SQ_W-1:0]  sq;    // cand*cand >> 30
        logic [NUM_W-1:0] rem;   // linear segment remainder
        logic [F_W-1:0]   quot;  // linear segment quotient
    } cmp_lane_t;

    // Q30 product, truncated
    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Largest q <= 1.0 with q^5 <= s
    function automatic logic [63:0] root5(input logic [63:0] s);
        logic [63:0] y;
        logic [63:0] c;
        logic [63:0] p;
        y = '0;
        if (s >= ONE_Q30)
        begin
            return ONE_Q30;
        end
        for (int k = 29; k >= 0; k--)
        begin
            c = y | (64'd1 << k);
            p = mul30(mul30(mul30(mul30(c, c), c), c), c);
            if (p <= s)
            begin
                y = c;
            end
        end
        return y;
    endfunction

    // sRGB transfer curve for one channel byte
    function automatic logic [63:0] lin_value(input logic [63:0] v);
        logic [63:0] t;
        logic [63:0] s;
        if (v <= 64'd10)
        begin
            return (v * 64'd10 * ONE_Q30 + 64'd16473) / 64'd32946;
        end
        t = ((v * 64'd1000 + 64'd14025) * ONE_Q30 + 64'd134512) / 64'd269025;
        s = mul30(t, t);
        return mul30(s, root5(s));
    endfunction

    function automatic lin_arr_t build_lin_table();
        lin_arr_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = LIN_W'(lin_value(64'(i)));
        end
        return tab;
    endfunction

    localparam lin_arr_t LIN_TABLE = build_lin_table();

    // sRGB to XYZ matrix, row major, scaled by 1e7
    localparam logic [COEF_W-1:0] MAT_COEF [9] = '{
        24'd4124564, 24'd3575761, 24'd1804375,
        24'd2126729, 24'd7151522, 24'd721750,
        24'd193339,  24'd1191920, 24'd9503041
    };

    // D65 white point scaled by 1e7
    localparam logic [COEF_W-1:0] WHITE_DIV [3] = '{24'd9504560, 24'd10000000, 24'd10887540};

    // floor(2^(DIV_PRE+RCP_W) / white point); estimate is at most two low
    localparam logic [RCP_W-1:0] WHITE_RCP [3] = '{
        RCP_W'((64'd1 << (DIV_PRE + RCP_W)) / 64'd9504560),
        RCP_W'((64'd1 << (DIV_PRE + RCP_W)) / 64'd10000000),
        RCP_W'((64'd1 << (DIV_PRE + RCP_W)) / 64'd10887540)
    };

    // Epsilon threshold: x*1e6 > 8856*2^30  <=>  x > CB_THRESH
    localparam logic [F_W-1:0] CB_THRESH = F_W'((64'd8856 << 30) / 64'd1000000);

    // Linear segment: (9033*x + 160*2^30 + 580) / 1160
    localparam logic [NUM_W-1:0] LIN_MUL = NUM_W'(9033);
    localparam logic [NUM_W-1:0] LIN_OFS = NUM_W'((64'd160 << 30) + 64'd580);
    localparam logic [NUM_W-1:0] LIN_DIV = NUM_W'(1160);

    // floor(2^(LIN_PRE+RCP_W) / 1160); estimate is at most one low
    localparam logic [RCP_W-1:0] LIN_RCP = RCP_W'((64'd1 << (LIN_PRE + RCP_W)) / 64'd1160);

endpackage

/* rtl/s2l_pix_if.sv */
interface s2l_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink (input valid, red, green, blue, frame_end, output ready);
endinterface

/* rtl/s2l_lab_if.sv */
interface s2l_lab_if;
    logic               valid;
    logic               ready;
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    logic               frame_end_out;

    modport source (output valid, lightness, green_red, blue_yellow, frame_end_out, input ready);
    modport sink (input valid, lightness, green_red, blue_yellow, frame_end_out, output ready);
endinterface

/* rtl/srgb_to_cielab_converter.sv */
// Channel   Dir  Item fields
// pixel     in   red[7:0], green[7:0], blue[7:0], frame_end
// lab       out  lightness[14:0], green_red[15:0], blue_yellow[15:0], frame_end_out
//
// One item per clock unless the pipeline holds; pipeline stages: 3 gamma/matrix, 3 white point
// division, 64 compand (entry, two per cube root bit, segment pick), 2 output.
// rst_n clears only the valid bits; the data and frame_end registers are not reset.
// The pipeline holds as a whole while lab is valid and not ready; pixel.ready
// then drops, and nothing is lost or repeated.
module srgb_to_cielab_converter #(
    parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    s2l_pix_if.sink    pixel,
    s2l_lab_if.source  lab
);
    import s2l_pkg::*;

    logic             en;
    logic             lin_vld;
    logic             lin_fe;
    logic [SUM_W-1:0] lin_sum [3];
    logic             div_vld;
    logic             div_fe;
    logic [F_W-1:0]   div_q [3];
    logic             cmp_vld;
    logic             cmp_fe;
    logic [F_W-1:0]   cmp_f [3];

    // global advance: the output register is free or being drained
    assign en          = !lab.valid || lab.ready;
    assign pixel.ready = en;

    s2l_lin u_lin (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (pixel.valid),
        .red           (pixel.red),
        .green         (pixel.green),
        .blue          (pixel.blue),
        .in_frame_end  (pixel.frame_end),
        .out_valid     (lin_vld),
        .out_frame_end (lin_fe),
        .sum           (lin_sum)
    );

    s2l_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (lin_vld),
        .in_frame_end  (lin_fe),
        .sum           (lin_sum),
        .out_valid     (div_vld),
        .out_frame_end (div_fe),
        .quot          (div_q)
    );

    s2l_cmp u_cmp (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (div_vld),
        .in_frame_end  (div_fe),
        .x             (div_q),
        .out_valid     (cmp_vld),
        .out_frame_end (cmp_fe),
        .f             (cmp_f)
    );

    s2l_lab #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lab (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (cmp_vld),
        .in_frame_end  (cmp_fe),
        .f             (cmp_f),
        .out_valid     (lab.valid),
        .out_frame_end (lab.frame_end_out),
        .lightness     (lab.lightness),
        .green_red     (lab.green_red),
        .blue_yellow   (lab.blue_yellow)
    );
endmodule

/* rtl/s2l_lin.sv */
module s2l_lin (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic                       in_frame_end,
    output logic                       out_valid,
    output logic                       out_frame_end,
    output logic [s2l_pkg::SUM_W-1:0]  sum [3]
);
    import s2l_pkg::*;

    logic             vld_reg [3];
    logic             fe_reg [3];
    logic [LIN_W-1:0] lin_reg [3];
    logic [SUM_W-1:0] prod_reg [9];
    logic [SUM_W-1:0] sum_reg [3];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    // gamma lookup, matrix products, row sums with rounding offset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_reg[0]  <= in_frame_end;
            fe_reg[1]  <= fe_reg[0];
            fe_reg[2]  <= fe_reg[1];
            lin_reg[0] <= LIN_TABLE[red];
            lin_reg[1] <= LIN_TABLE[green];
            lin_reg[2] <= LIN_TABLE[blue];
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= SUM_W'(lin_reg[i % 3]) * SUM_W'(MAT_COEF[i]);
            end
            for (int l = 0; l < 3; l++)
            begin
                sum_reg[l] <= prod_reg[3*l] + prod_reg[3*l+1] + prod_reg[3*l+2]
                              + SUM_W'(WHITE_DIV[l] >> 1);
            end
        end
    end

    assign out_valid     = vld_reg[2];
    assign out_frame_end = fe_reg[2];
    assign sum           = sum_reg;
endmodule

/* rtl/s2l_div.sv */
module s2l_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       in_frame_end,
    input  logic [s2l_pkg::SUM_W-1:0]  sum [3],
    output logic                       out_valid,
    output logic                       out_frame_end,
    output logic [s2l_pkg::F_W-1:0]    quot [3]
);
    import s2l_pkg::*;

    logic [2*RCP_W-1:0] prod_reg [3];
    logic [SUM_W-1:0]   num0_reg [3];
    logic [SUM_W-1:0]   num1_reg [3];
    logic [F_W-1:0]     qe_reg [3];
    logic [SUM_W-1:0]   qd_reg [3];
    logic [F_W-1:0]     quot_reg [3];
    logic [SUM_W-1:0]   rem [3];
    logic               vld_reg [3];
    logic               fe_reg [3];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    // remainder left by the estimate, below three divisors
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rem[l] = num1_reg[l] - qd_reg[l];
        end
    end

    // division by the white point: reciprocal estimate, back-multiply, correct
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_reg[0] <= in_frame_end;
            fe_reg[1] <= fe_reg[0];
            fe_reg[2] <= fe_reg[1];
            for (int l = 0; l < 3; l++)
            begin
                prod_reg[l] <= (2*RCP_W)'(sum[l][F_W+DIV_PRE-1:DIV_PRE])
                               * (2*RCP_W)'(WHITE_RCP[l]);
                num0_reg[l] <= sum[l];
                qe_reg[l]   <= prod_reg[l][F_W+RCP_W-1:RCP_W];
                qd_reg[l]   <= SUM_W'(prod_reg[l][F_W+RCP_W-1:RCP_W]) * SUM_W'(WHITE_DIV[l]);
                num1_reg[l] <= num0_reg[l];
                if (rem[l] >= (SUM_W'(WHITE_DIV[l]) << 1))
                begin
                    quot_reg[l] <= qe_reg[l] + F_W'(2);
                end
                else if (rem[l] >= SUM_W'(WHITE_DIV[l]))
                begin
                    quot_reg[l] <= qe_reg[l] + F_W'(1);
                end
                else
                begin
                    quot_reg[l] <= qe_reg[l];
                end
            end
        end
    end

    assign out_valid     = vld_reg[2];
    assign out_frame_end = fe_reg[2];
    assign quot          = quot_reg;
endmodule

/* rtl/s2l_cmp.sv */
module s2l_cmp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     in_frame_end,
    input  logic [s2l_pkg::F_W-1:0]  x [3],
    output logic                     out_valid,
    output logic                     out_frame_end,
    output logic [s2l_pkg::F_W-1:0]  f [3]
);
    import s2l_pkg::*;

    cmp_lane_t      ent_reg [3];
    logic           ent_vld_reg;
    logic           ent_fe_reg;
    cmp_lane_t      a_reg [F_W][3];
    logic           a_vld_reg [F_W];
    logic           a_fe_reg [F_W];
    cmp_lane_t      b_reg [F_W][3];
    logic           b_vld_reg [F_W];
    logic           b_fe_reg [F_W];
    logic [F_W-1:0] f_reg [3];
    logic           f_vld_reg;
    logic           f_fe_reg;

    // entry: segment select and linear numerator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_fe_reg <= in_frame_end;
            for (int l = 0; l < 3; l++)
            begin
                ent_reg[l].lin  <= (x[l] <= CB_THRESH);
                ent_reg[l].x    <= x[l];
                ent_reg[l].c    <= '0;
                ent_reg[l].cand <= '0;
                ent_reg[l].sq   <= '0;
                ent_reg[l].rem  <= NUM_W'(x[l]) * LIN_MUL + LIN_OFS;
                ent_reg[l].quot <= '0;
            end
        end
    end

    // two stages per root bit: square, then cube and compare
    for (genvar j = 0; j < F_W; j++)
    begin : g_step
        localparam int B = F_W - 1 - j;
        cmp_lane_t             a_in [3];
        cmp_lane_t             a_nx [3];
        cmp_lane_t             b_nx [3];
        logic                  vld_in;
        logic                  fe_in;
        logic [2*F_W-1:0]      sq_full [3];
        logic [F_W+SQ_W-1:0]   cube_full [3];
        logic [CUBE_W-1:0]     cube [3];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                a_in   = ent_reg;
                vld_in = ent_vld_reg;
                fe_in  = ent_fe_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                a_in   = b_reg[j-1];
                vld_in = b_vld_reg[j-1];
                fe_in  = b_fe_reg[j-1];
            end
        end

        // square of the candidate; linear segment estimate, then its correction
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                a_nx[l]      = a_in[l];
                a_nx[l].cand = a_in[l].c | (F_W'(1) << B);
                sq_full[l]   = (2*F_W)'(a_nx[l].cand) * (2*F_W)'(a_nx[l].cand);
                a_nx[l].sq   = sq_full[l][SQ_W+29:30];
                if (j == 0)
                begin
                    a_nx[l].quot = F_W'(((2*RCP_W)'(a_in[l].rem[LIN_PRE+LQ_W-1:LIN_PRE])
                                         * (2*RCP_W)'(LIN_RCP)) >> RCP_W);
                end
                else if ((j == 1) && (a_in[l].rem >= LIN_DIV))
                begin
                    a_nx[l].quot = a_in[l].quot + F_W'(1);
                end
            end
        end

        // cube of the candidate, keep the bit if it stays at or below x;
        // first stage also forms the linear remainder
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                b_nx[l]      = a_reg[j][l];
                cube_full[l] = (F_W+SQ_W)'(a_reg[j][l].sq) * (F_W+SQ_W)'(a_reg[j][l].cand);
                cube[l]      = cube_full[l][F_W+SQ_W-1:30];
                if (cube[l] <= CUBE_W'(a_reg[j][l].x))
                begin
                    b_nx[l].c = a_reg[j][l].cand;
                end
                if (j == 0)
                begin
                    b_nx[l].rem = a_reg[j][l].rem - NUM_W'(a_reg[j][l].quot) * LIN_DIV;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg[j] <= 1'b0;
                b_vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                a_vld_reg[j] <= vld_in;
                b_vld_reg[j] <= a_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_fe_reg[j] <= fe_in;
                b_fe_reg[j] <= a_fe_reg[j];
                a_reg[j]    <= a_nx;
                b_reg[j]    <= b_nx;
            end
        end
    end

    // control of entry and final stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= 1'b0;
            f_vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            ent_vld_reg <= in_valid;
            f_vld_reg   <= b_vld_reg[F_W-1];
        end
    end

    // pick the segment
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_fe_reg <= b_fe_reg[F_W-1];
            for (int l = 0; l < 3; l++)
            begin
                f_reg[l] <= b_reg[F_W-1][l].lin ? b_reg[F_W-1][l].quot : b_reg[F_W-1][l].c;
            end
        end
    end

    assign out_valid     = f_vld_reg;
    assign out_frame_end = f_fe_reg;
    assign f             = f_reg;
endmodule

/* rtl/s2l_lab.sv */
module s2l_lab #(
    parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     in_frame_end,
    input  logic [s2l_pkg::F_W-1:0]  f [3],
    output logic                     out_valid,
    output logic                     out_frame_end,
    output logic [14:0]              lightness,
    output logic signed [15:0]       green_red,
    output logic signed [15:0]       blue_yellow
);
    import s2l_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam logic [RAW_W-1:0] HALF = RAW_W'(1) << (SH - 1);
    localparam logic signed [RAW_W-1:0] K_L   = RAW_W'(116);
    localparam logic signed [RAW_W-1:0] K_A   = RAW_W'(500);
    localparam logic signed [RAW_W-1:0] K_B   = RAW_W'(200);
    localparam logic signed [RAW_W-1:0] L_OFS = RAW_W'(16) << 30;
    localparam logic signed [RAW_W-1:0] L_MAX =
        ((100 << FRAC_BITS) > 32767) ? RAW_W'(32767) : RAW_W'(100 << FRAC_BITS);
    localparam logic signed [RAW_W-1:0] C_MAX = RAW_W'(32767);
    localparam logic signed [RAW_W-1:0] C_MIN = -RAW_W'(32768);

    logic signed [RAW_W-1:0] fx;
    logic signed [RAW_W-1:0] fy;
    logic signed [RAW_W-1:0] fz;
    logic signed [RAW_W-1:0] l_raw_reg;
    logic signed [RAW_W-1:0] a_raw_reg;
    logic signed [RAW_W-1:0] b_raw_reg;
    logic signed [RAW_W-1:0] l_rnd;
    logic signed [RAW_W-1:0] a_rnd;
    logic signed [RAW_W-1:0] b_rnd;
    logic                    vld_reg;
    logic                    fe_reg;
    logic                    out_vld_reg;
    logic                    out_fe_reg;
    logic [14:0]             l_reg;
    logic signed [15:0]      a_reg;
    logic signed [15:0]      b_reg;

    // round to FRAC_BITS, half away from zero
    function automatic logic signed [RAW_W-1:0] round_q(input logic signed [RAW_W-1:0] v);
        logic [RAW_W-1:0] mag;
        logic [RAW_W-1:0] r;
        mag = (v < 0) ? RAW_W'(-v) : RAW_W'(v);
        r   = (mag + HALF) >> SH;
        return (v < 0) ? -signed'(r) : signed'(r);
    endfunction

    function automatic logic signed [RAW_W-1:0] clamp(input logic signed [RAW_W-1:0] v,
                                                      input logic signed [RAW_W-1:0] lo,
                                                      input logic signed [RAW_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    assign fx = signed'(RAW_W'(f[0]));
    assign fy = signed'(RAW_W'(f[1]));
    assign fz = signed'(RAW_W'(f[2]));

    assign l_rnd = round_q(l_raw_reg);
    assign a_rnd = round_q(a_raw_reg);
    assign b_rnd = round_q(b_raw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= in_valid;
            out_vld_reg <= vld_reg;
        end
    end

    // scale and offset, then round and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_reg     <= in_frame_end;
            l_raw_reg  <= fy * K_L - L_OFS;
            a_raw_reg  <= (fx - fy) * K_A;
            b_raw_reg  <= (fy - fz) * K_B;
            out_fe_reg <= fe_reg;
            l_reg      <= 15'(clamp(l_rnd, '0, L_MAX));
            a_reg      <= 16'(clamp(a_rnd, C_MIN, C_MAX));
            b_reg      <= 16'(clamp(b_rnd, C_MIN, C_MAX));
        end
    end

    assign out_valid     = out_vld_reg;
    assign out_frame_end = out_fe_reg;
    assign lightness     = l_reg;
    assign green_red     = a_reg;
    assign blue_yellow   = b_reg;
endmodule
